[rtl/lsdp_pkg.sv]
package lsdp_pkg;

    localparam int CORES     = 4;
    localparam int SETS      = 64;
    localparam int MAX_DEPTH = 16;

    localparam int CORE_W  = 2;
    localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int POS_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int FILL_W  = $clog2(MAX_DEPTH + 1);
    localparam int BINS    = MAX_DEPTH + 1;
    localparam int BIN_W   = $clog2(BINS + 1);
    localparam int ROW_W   = $clog2(CORES * SETS);
    localparam int HADDR_W = $clog2(CORES * BINS);
    localparam int LINE_W  = 48;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 37;

    localparam logic [1:0] FUNC_MISS  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    localparam logic [1:0] REG_LINE_SHIFT = 2'd0;
    localparam logic [1:0] REG_DEPTH      = 2'd1;

    typedef logic [LINE_W-1:0] line_t;
    typedef line_t [MAX_DEPTH-1:0] row_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

[rtl/lsdp_tag_ram.sv]
module lsdp_tag_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [lsdp_pkg::ROW_W-1:0]   waddr,
    input  lsdp_pkg::row_t               wdata,
    input  logic [lsdp_pkg::FILL_W-1:0]  wfill,
    input  logic [lsdp_pkg::ROW_W-1:0]   raddr,
    output lsdp_pkg::row_t               rdata,
    output logic [lsdp_pkg::FILL_W-1:0]  rfill
);
    lsdp_pkg::row_t mem [lsdp_pkg::CORES*lsdp_pkg::SETS];
    // per-set count of valid stack positions, stored beside the row
    logic [lsdp_pkg::FILL_W-1:0] fill_mem [lsdp_pkg::CORES*lsdp_pkg::SETS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr]      <= wdata;
            fill_mem[waddr] <= wfill;
        end
        rdata <= mem[raddr];
        rfill <= fill_mem[raddr];
    end
endmodule

[rtl/lsdp_hist_ram.sv]
module lsdp_hist_ram (
    input  logic                           clk,
    input  logic                           we,
    input  logic [lsdp_pkg::HADDR_W-1:0]   waddr,
    input  logic [lsdp_pkg::CNT_W-1:0]     wdata,
    input  logic [lsdp_pkg::HADDR_W-1:0]   raddr,
    output logic [lsdp_pkg::CNT_W-1:0]     rdata
);
    logic [lsdp_pkg::CNT_W-1:0] mem [lsdp_pkg::CORES*lsdp_pkg::BINS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/lru_stack_distance_profiler.sv]
// LRU stack distance profiler. A command is taken when start is high and busy
// is low; exactly one result follows, shown for one cycle with done high, and
// it cannot be held off. A new command can be taken in the cycle the result is
// shown. A miss (func 0) keeps busy high until its result, so a new miss is
// taken only after the last is through: the set row and its fill count are
// read from the tag memory, compared at all positions at once, shifted and
// written back, then the histogram bin is read, incremented and written. A
// range read (func 1) keeps busy high while it reads and sums each bin in
// turn through the single read port of the histogram memory; an empty range
// goes straight to its result. A clear keeps busy high while it sweeps all
// histogram bins (68 by default). After reset the same sweep runs to zero the
// histogram (busy high, no result). Each set's fill count sits in the tag
// memory next to its row, gated by a per-set valid flag that reset clears, so
// an untouched set reads as empty.
module lru_stack_distance_profiler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [1:0]  core_id,
    input  logic [47:0] address,
    input  logic [4:0]  range_begin,
    input  logic [4:0]  range_end,
    output logic        done,
    output logic        reuse_found,
    output logic [3:0]  stack_position,
    output logic [36:0] range_count,
    output logic [31:0] miss_count
);
    localparam int PW  = lsdp_pkg::POS_W;
    localparam int FW  = lsdp_pkg::FILL_W;
    localparam int MD  = lsdp_pkg::MAX_DEPTH;
    localparam int HW  = lsdp_pkg::HADDR_W;
    localparam int BW  = lsdp_pkg::BIN_W;
    localparam int NB  = lsdp_pkg::BINS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_TAG   = 8'b00000010,
        S_CMP   = 8'b00000100,
        S_HINC  = 8'b00001000,
        S_SUMRD = 8'b00010000,
        S_SUMAC = 8'b00100000,
        S_CLR   = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0] line_shift_reg;
    logic [4:0] depth_in_use_reg;
    logic [lsdp_pkg::CORES*lsdp_pkg::SETS-1:0] row_valid_reg;
    logic [31:0] miss_reg [lsdp_pkg::CORES];

    // captured transaction
    logic [1:0]  func_reg;
    logic [1:0]  core_reg;
    lsdp_pkg::line_t line_reg;
    logic [lsdp_pkg::ROW_W-1:0] row_reg;
    logic [BW-1:0] bin_reg, bin_end_reg;
    logic [HW-1:0] clr_reg;
    logic        found_reg;
    logic [PW-1:0] pos_reg;
    logic [36:0] sum_reg;
    logic [31:0] misses_reg;

    // clamped depth
    logic [FW-1:0] depth;
    always_comb
    begin
        if (depth_in_use_reg == 5'd0)
            depth = FW'(1);
        else if (32'(depth_in_use_reg) > MD)
            depth = FW'(MD);
        else
            depth = FW'(depth_in_use_reg);
    end

    lsdp_pkg::row_t tag_rdata, tag_wdata;
    logic [FW-1:0] fill_rdata, fill_wdata;
    logic tag_we;
    lsdp_tag_ram u_tag (
        .clk  (clk),
        .we   (tag_we),
        .waddr(row_reg),
        .wdata(tag_wdata),
        .wfill(fill_wdata),
        .raddr(row_reg),
        .rdata(tag_rdata),
        .rfill(fill_rdata)
    );

    logic h_we;
    logic [HW-1:0] h_waddr, h_raddr;
    logic [31:0] h_wdata, h_rdata;
    lsdp_hist_ram u_hist (
        .clk  (clk),
        .we   (h_we),
        .waddr(h_waddr),
        .wdata(h_wdata),
        .raddr(h_raddr),
        .rdata(h_rdata)
    );

    // line number and set of the incoming miss
    lsdp_pkg::line_t in_line;
    assign in_line = address >> line_shift_reg;

    // parallel compare against the valid part of the row
    logic [FW-1:0] n_eff;
    logic          hit;
    logic [PW-1:0] hit_pos;
    always_comb
    begin
        if (!row_valid_reg[row_reg])
            n_eff = '0;
        else
            n_eff = (fill_rdata > depth) ? depth : fill_rdata;
        hit = 1'b0;
        hit_pos = '0;
        for (int i = MD - 1; i >= 0; i--)
        begin
            if (FW'(i) < n_eff && tag_rdata[i] == line_reg)
            begin
                hit = 1'b1;
                hit_pos = PW'(i);
            end
        end
    end

    // shift positions below last down by one, insert at front
    logic [FW-1:0] last;
    always_comb
    begin
        if (hit)
            last = FW'(hit_pos);
        else if (n_eff >= depth)
            last = depth - 1'b1;
        else
            last = n_eff;
        for (int i = 0; i < MD; i++)
        begin
            if (i == 0)
                tag_wdata[i] = line_reg;
            else if (FW'(i) <= last)
                tag_wdata[i] = tag_rdata[i-1];
            else
                tag_wdata[i] = tag_rdata[i];
        end
    end
    assign fill_wdata = hit ? n_eff
                      : ((n_eff + 1'b1 > depth) ? depth : n_eff + 1'b1);
    assign tag_we = (state_reg == S_CMP);

    // histogram base of the captured core
    logic [HW-1:0] hbase;
    assign hbase = HW'(32'(core_reg) * NB);

    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = clr_reg;
        h_wdata = '0;
        h_raddr = hbase + HW'(bin_reg);
        case (state_reg)
            S_CMP:
            begin
                h_raddr = hbase + HW'(hit_pos);
            end
            S_HINC:
            begin
                h_we    = found_reg;
                h_waddr = hbase + HW'(pos_reg);
                h_wdata = lsdp_pkg::sat_inc(h_rdata);
            end
            S_CLR:
            begin
                h_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    logic accept;
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // clipped range bounds
    logic [BW-1:0] size, rb_c, re_c;
    always_comb
    begin
        size = BW'(depth) + 1'b1;
        rb_c = (BW'(range_begin) > size || 32'(range_begin) > NB) ? size : BW'(range_begin);
        re_c = (BW'(range_end) > size || 32'(range_end) > NB) ? size : BW'(range_end);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && 32'(core_id) < lsdp_pkg::CORES)
                begin
                    case (func)
                        lsdp_pkg::FUNC_MISS:  state_next = S_TAG;
                        lsdp_pkg::FUNC_READ:  state_next = (rb_c < re_c) ? S_SUMRD : S_DONE;
                        lsdp_pkg::FUNC_CLEAR: state_next = S_CLR;
                        default:              state_next = S_DONE;
                    endcase
                end
                else if (accept)
                begin
                    state_next = S_DONE;
                end
            end
            S_TAG:   state_next = S_CMP;
            S_CMP:   state_next = S_HINC;
            S_HINC:  state_next = S_DONE;
            S_SUMRD: state_next = S_SUMAC;
            S_SUMAC: state_next = (bin_reg + 1'b1 < bin_end_reg) ? S_SUMRD : S_DONE;
            // the sweep after reset ends without a result
            S_CLR:
            begin
                if (32'(clr_reg) == lsdp_pkg::CORES * NB - 1)
                    state_next = (func_reg == lsdp_pkg::FUNC_CLEAR) ? S_DONE : S_IDLE;
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLR;
            line_shift_reg   <= 4'd6;
            depth_in_use_reg <= 5'd16;
            clr_reg          <= '0;
            func_reg         <= lsdp_pkg::FUNC_NONE;
            core_reg         <= '0;
            row_valid_reg    <= '0;
            for (int i = 0; i < lsdp_pkg::CORES; i++)
                miss_reg[i] <= '0;
            done <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_reg == S_DONE);
            if (cfg_we)
            begin
                if (cfg_index == lsdp_pkg::REG_LINE_SHIFT)
                    line_shift_reg <= cfg_data[3:0];
                else if (cfg_index == lsdp_pkg::REG_DEPTH)
                    depth_in_use_reg <= cfg_data;
            end
            if (accept)
            begin
                func_reg <= (32'(core_id) < lsdp_pkg::CORES) ? func : lsdp_pkg::FUNC_NONE;
                core_reg <= core_id;
                clr_reg  <= '0;
            end
            case (state_reg)
                S_CMP:
                begin
                    row_valid_reg[row_reg] <= 1'b1;
                    miss_reg[core_reg] <= lsdp_pkg::sat_inc(miss_reg[core_reg]);
                end
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == lsdp_pkg::CORES * NB - 1 &&
                        func_reg == lsdp_pkg::FUNC_CLEAR)
                    begin
                        for (int i = 0; i < lsdp_pkg::CORES; i++)
                            miss_reg[i] <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_reg    <= in_line;
            row_reg     <= lsdp_pkg::ROW_W'(32'(core_id) * lsdp_pkg::SETS)
                         + lsdp_pkg::ROW_W'(in_line[lsdp_pkg::SET_W-1:0]);
            bin_reg     <= rb_c;
            bin_end_reg <= re_c;
            found_reg   <= 1'b0;
            pos_reg     <= '0;
            sum_reg     <= '0;
            misses_reg  <= '0;
        end
        case (state_reg)
            S_CMP:
            begin
                found_reg  <= hit;
                pos_reg    <= hit ? hit_pos : '0;
                misses_reg <= lsdp_pkg::sat_inc(miss_reg[core_reg]);
            end
            S_SUMAC:
            begin
                sum_reg <= sum_reg + 37'(h_rdata);
                bin_reg <= bin_reg + 1'b1;
            end
            S_DONE:
            begin
                reuse_found    <= found_reg;
                stack_position <= 4'(pos_reg);
                range_count    <= (func_reg == lsdp_pkg::FUNC_READ) ? sum_reg : '0;
                miss_count     <= (func_reg == lsdp_pkg::FUNC_READ) ? miss_reg[core_reg]
                                : (func_reg == lsdp_pkg::FUNC_MISS) ? misses_reg : '0;
            end
            default:
            begin
            end
        endcase
    end
endmodule
